// ===== rtl/translation_page_cache_manager_assert.svh =====
// assertion macros included by the page cache engine
`ifndef TRANSLATION_PAGE_CACHE_MANAGER_ASSERT_SVH
`define TRANSLATION_PAGE_CACHE_MANAGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpc_pkg.sv =====
// shared constants, codes and types of the translation page cache
`default_nettype none
package tpc_pkg;

  localparam int NUM_SLOTS        = 256;
  localparam int NUM_FRAGMENTS    = 1024;
  localparam int MAP_PAGES        = 16384;
  localparam int ENTRIES_PER_PAGE = 1024;
  localparam int EXTRA_FLUSH      = 4;

  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int FRAG_W     = $clog2(NUM_FRAGMENTS);
  localparam int PAGE_W     = $clog2(MAP_PAGES);
  localparam int WORD_W     = $clog2(ENTRIES_PER_PAGE);
  localparam int ETAB_DEPTH = NUM_SLOTS * ENTRIES_PER_PAGE;
  localparam int ETAB_W     = SLOT_W + WORD_W;
  localparam int GPN_W      = 20;
  localparam int SPN_W      = GPN_W + 1;
  localparam int OFS_W      = 31;

  // sweep length after reset covers the largest memory
  localparam int CLR_DEPTH0 = (ETAB_DEPTH > MAP_PAGES) ? ETAB_DEPTH : MAP_PAGES;
  localparam int CLR_DEPTH  = (CLR_DEPTH0 > NUM_FRAGMENTS) ? CLR_DEPTH0 : NUM_FRAGMENTS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  localparam logic [31:0] MEMSIZE_RESET = 32'd67108864;

  // slot and fragment numbers carry a none flag in the top bit
  localparam logic [SLOT_W:0] SLOT_NIL = {1'b1, {SLOT_W{1'b0}}};
  localparam logic [FRAG_W:0] FRAG_NIL = {1'b1, {FRAG_W{1'b0}}};
  localparam logic [SPN_W-1:0] SPN_UNMAPPED = {1'b1, {GPN_W{1'b0}}};

  // operation codes
  localparam logic [1:0] OP_NEW_PC     = 2'd0;
  localparam logic [1:0] OP_ALLOC_FRAG = 2'd1;
  localparam logic [1:0] OP_RECORD     = 2'd2;
  localparam logic [1:0] OP_INVALIDATE = 2'd3;

  // status codes
  localparam logic [2:0] STATUS_DONE  = 3'd0;
  localparam logic [2:0] STATUS_HIT   = 3'd1;
  localparam logic [2:0] STATUS_MISS  = 3'd2;
  localparam logic [2:0] STATUS_EMPTY = 3'd3;
  localparam logic [2:0] STATUS_OOR   = 3'd4;

  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      address;
    logic [7:0]       slot;
    logic [OFS_W-1:0] cache_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       page_slot;
    logic [OFS_W-1:0] entry_offset;
    logic [9:0]       fragment_index;
    logic [2:0]       flushed_count;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/tpc_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
`default_nettype none
module tpc_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/tpc_engine.sv =====
// sequencer over the page map, slot lists, fragment chains and entry table
`default_nettype none
module tpc_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tpc_pkg::req_t req,
  input  wire logic [31:0]   memory_size,
  output logic               idle,
  output logic               done,
  output tpc_pkg::res_t      res,
  input  wire logic          res_ready
);

  `include "translation_page_cache_manager_assert.svh"

  localparam int SW  = tpc_pkg::SLOT_W;
  localparam int FW  = tpc_pkg::FRAG_W;
  localparam int PW  = tpc_pkg::PAGE_W;
  localparam int EW  = tpc_pkg::ETAB_W;
  localparam int CW  = tpc_pkg::CLR_W;
  localparam int SPW = tpc_pkg::SPN_W;
  localparam int OW  = tpc_pkg::OFS_W;

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE, ST_DEC,
    ST_N_MAP, ST_K1, ST_K2, ST_N_RT, ST_N_EX, ST_N_EXT, ST_N_SET, ST_N_LOOK, ST_N_RES,
    ST_A_FREE, ST_A_CHK, ST_A_POP,
    ST_R_MAP, ST_R_CHK,
    ST_I_FREE, ST_I_END,
    ST_T0, ST_T1, ST_T2, ST_T3,
    ST_F0, ST_F1, ST_F2, ST_FW0, ST_FW1, ST_FC,
    ST_U0, ST_U1, ST_U2,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  tpc_pkg::req_t req_r, req_nxt;
  tpc_pkg::res_t res_r, res_nxt;
  logic [SW-1:0]  s_r, s_nxt, tgt_r, tgt_nxt;
  logic [SW:0]    lru_r, lru_nxt, mru_r, mru_nxt, free_r, free_nxt;
  logic [FW:0]    ffh_r, ffh_nxt, f_r, f_nxt;
  logic [SPW-1:0] pg_r, pg_nxt;
  logic [FW:0]    guard_r, guard_nxt;
  logic [tpc_pkg::WORD_W-1:0] k_r, k_nxt;
  logic [2:0]     xk_r, xk_nxt, flushed_r, flushed_nxt;
  logic [CW-1:0]  clr_r, clr_nxt;
  logic [tpc_pkg::NUM_SLOTS-1:0] in_use_r, in_use_nxt;

  // memory ports
  logic          pmap_we;  logic [PW-1:0] pmap_wa, pmap_ra; logic [SW:0] pmap_wd, pmap_rd;
  logic          spn_we;   logic [SW-1:0] spn_wa, spn_ra;   logic [SPW-1:0] spn_wd, spn_rd;
  logic          mrl_we;   logic [SW-1:0] mrl_wa, mrl_ra;   logic [SW:0] mrl_wd, mrl_rd;
  logic          lrl_we;   logic [SW-1:0] lrl_wa, lrl_ra;   logic [SW:0] lrl_wd, lrl_rd;
  logic          fhd_we;   logic [SW-1:0] fhd_wa, fhd_ra;   logic [FW:0] fhd_wd, fhd_rd;
  logic          fnx_we;   logic [FW-1:0] fnx_wa, fnx_ra;   logic [FW:0] fnx_wd, fnx_rd;
  logic          etab_we;  logic [EW-1:0] etab_wa, etab_ra; logic [OW-1:0] etab_wd, etab_rd;

  tpc_ram #(.DEPTH(tpc_pkg::MAP_PAGES), .WIDTH(SW + 1)) u_pmap (
    .clk(clk), .we(pmap_we), .waddr(pmap_wa), .wdata(pmap_wd), .raddr(pmap_ra), .rdata(pmap_rd));
  tpc_ram #(.DEPTH(tpc_pkg::NUM_SLOTS), .WIDTH(SPW)) u_spn (
    .clk(clk), .we(spn_we), .waddr(spn_wa), .wdata(spn_wd), .raddr(spn_ra), .rdata(spn_rd));
  tpc_ram #(.DEPTH(tpc_pkg::NUM_SLOTS), .WIDTH(SW + 1)) u_mrl (
    .clk(clk), .we(mrl_we), .waddr(mrl_wa), .wdata(mrl_wd), .raddr(mrl_ra), .rdata(mrl_rd));
  tpc_ram #(.DEPTH(tpc_pkg::NUM_SLOTS), .WIDTH(SW + 1)) u_lrl (
    .clk(clk), .we(lrl_we), .waddr(lrl_wa), .wdata(lrl_wd), .raddr(lrl_ra), .rdata(lrl_rd));
  tpc_ram #(.DEPTH(tpc_pkg::NUM_SLOTS), .WIDTH(FW + 1)) u_fhd (
    .clk(clk), .we(fhd_we), .waddr(fhd_wa), .wdata(fhd_wd), .raddr(fhd_ra), .rdata(fhd_rd));
  tpc_ram #(.DEPTH(tpc_pkg::NUM_FRAGMENTS), .WIDTH(FW + 1)) u_fnx (
    .clk(clk), .we(fnx_we), .waddr(fnx_wa), .wdata(fnx_wd), .raddr(fnx_ra), .rdata(fnx_rd));
  tpc_ram #(.DEPTH(tpc_pkg::ETAB_DEPTH), .WIDTH(OW)) u_etab (
    .clk(clk), .we(etab_we), .waddr(etab_wa), .wdata(etab_wd), .raddr(etab_ra),
    .rdata(etab_rd));

  // decoded request fields
  logic [tpc_pkg::GPN_W-1:0]  page;
  logic [tpc_pkg::WORD_W-1:0] word;
  logic [PW-1:0]              page_idx;
  logic [SW-1:0]              slot_sel;
  logic                       addr_ok, slot_ok;
  logic [CW:0]                clr_inc;

  assign page     = req_r.address[31:12];
  assign word     = req_r.address[11:2];
  assign page_idx = page[PW-1:0];
  assign slot_sel = SW'(req_r.slot);
  assign addr_ok  = (req_r.address <= memory_size) &&
                    ({1'b0, page} < (tpc_pkg::GPN_W + 1)'(tpc_pkg::MAP_PAGES));
  assign slot_ok  = ({1'b0, req_r.slot} < 9'(tpc_pkg::NUM_SLOTS)) && in_use_r[slot_sel];
  assign clr_inc  = {1'b0, clr_r} + 1'b1;

  function automatic logic frag_nil(input logic [FW:0] f);
    frag_nil = (f >= (FW + 1)'(tpc_pkg::NUM_FRAGMENTS));
  endfunction

  // next state and memory control
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    s_nxt       = s_r;
    tgt_nxt     = tgt_r;
    lru_nxt     = lru_r;
    mru_nxt     = mru_r;
    free_nxt    = free_r;
    ffh_nxt     = ffh_r;
    f_nxt       = f_r;
    pg_nxt      = pg_r;
    guard_nxt   = guard_r;
    k_nxt       = k_r;
    xk_nxt      = xk_r;
    flushed_nxt = flushed_r;
    clr_nxt     = clr_r;
    in_use_nxt  = in_use_r;
    pmap_we = 1'b0; pmap_wa = '0; pmap_wd = '0; pmap_ra = '0;
    spn_we  = 1'b0; spn_wa  = '0; spn_wd  = '0; spn_ra  = '0;
    mrl_we  = 1'b0; mrl_wa  = '0; mrl_wd  = '0; mrl_ra  = '0;
    lrl_we  = 1'b0; lrl_wa  = '0; lrl_wd  = '0; lrl_ra  = '0;
    fhd_we  = 1'b0; fhd_wa  = '0; fhd_wd  = '0; fhd_ra  = '0;
    fnx_we  = 1'b0; fnx_wa  = '0; fnx_wd  = '0; fnx_ra  = '0;
    etab_we = 1'b0; etab_wa = '0; etab_wd = '0; etab_ra = '0;

    case (state_r)
      // clearing sweep after reset
      ST_INIT: begin
        etab_we = (clr_r < CW'(tpc_pkg::ETAB_DEPTH - 1)) || (clr_r == CW'(tpc_pkg::ETAB_DEPTH - 1));
        etab_wa = EW'(clr_r);
        pmap_we = ({1'b0, clr_r} < (CW + 1)'(tpc_pkg::MAP_PAGES));
        pmap_wa = PW'(clr_r);
        pmap_wd = tpc_pkg::SLOT_NIL;
        spn_we  = ({1'b0, clr_r} < (CW + 1)'(tpc_pkg::NUM_SLOTS));
        spn_wa  = SW'(clr_r);
        spn_wd  = tpc_pkg::SPN_UNMAPPED;
        mrl_we  = spn_we;
        mrl_wa  = SW'(clr_r);
        mrl_wd  = (clr_inc < (CW + 1)'(tpc_pkg::NUM_SLOTS)) ? (SW + 1)'(clr_inc)
                                                             : tpc_pkg::SLOT_NIL;
        lrl_we  = spn_we;
        lrl_wa  = SW'(clr_r);
        lrl_wd  = tpc_pkg::SLOT_NIL;
        fhd_we  = spn_we;
        fhd_wa  = SW'(clr_r);
        fhd_wd  = tpc_pkg::FRAG_NIL;
        fnx_we  = ({1'b0, clr_r} < (CW + 1)'(tpc_pkg::NUM_FRAGMENTS));
        fnx_wa  = FW'(clr_r);
        fnx_wd  = (clr_inc < (CW + 1)'(tpc_pkg::NUM_FRAGMENTS)) ? (FW + 1)'(clr_inc)
                                                                 : tpc_pkg::FRAG_NIL;
        clr_nxt = CW'(clr_inc);
        if (clr_r == CW'(tpc_pkg::CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_nxt     = req;
          flushed_nxt = '0;
          xk_nxt      = '0;
          state_nxt   = ST_DEC;
        end
      end

      // dispatch on the operation
      ST_DEC: begin
        res_nxt = '{status: tpc_pkg::STATUS_OOR, page_slot: '0, entry_offset: '0,
                    fragment_index: '0, flushed_count: '0};
        case (req_r.op)
          tpc_pkg::OP_NEW_PC, tpc_pkg::OP_RECORD: begin
            pmap_ra = page_idx;
            if (!addr_ok) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = (req_r.op == tpc_pkg::OP_NEW_PC) ? ST_N_MAP : ST_R_MAP;
            end
          end
          tpc_pkg::OP_ALLOC_FRAG: begin
            if (!slot_ok) begin
              state_nxt = ST_DONE;
            end else if (frag_nil(ffh_r) && !lru_r[SW]) begin
              tgt_nxt     = lru_r[SW-1:0];
              flushed_nxt = 3'd1;
              ret_nxt     = ST_A_FREE;
              state_nxt   = ST_F0;
            end else begin
              state_nxt = ST_A_CHK;
            end
          end
          tpc_pkg::OP_INVALIDATE: begin
            if (!slot_ok) begin
              state_nxt = ST_DONE;
            end else begin
              tgt_nxt     = slot_sel;
              flushed_nxt = 3'd1;
              ret_nxt     = ST_I_FREE;
              state_nxt   = ST_F0;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      // lookup: page mapped, free slot, or reclaim the lru slot
      ST_N_MAP: begin
        if (!pmap_rd[SW]) begin
          s_nxt     = pmap_rd[SW-1:0];
          tgt_nxt   = pmap_rd[SW-1:0];
          ret_nxt   = ST_N_LOOK;
          state_nxt = ST_T0;
        end else if (!free_r[SW]) begin
          s_nxt     = free_r[SW-1:0];
          tgt_nxt   = free_r[SW-1:0];
          mrl_ra    = free_r[SW-1:0];
          state_nxt = ST_K1;
        end else begin
          s_nxt       = lru_r[SW-1:0];
          tgt_nxt     = lru_r[SW-1:0];
          flushed_nxt = 3'd1;
          ret_nxt     = ST_N_RT;
          state_nxt   = ST_F0;
        end
      end
      ST_K1: begin
        free_nxt  = mrl_rd;
        lrl_we    = 1'b1; lrl_wa = tgt_r; lrl_wd = mru_r;
        mrl_we    = 1'b1; mrl_wa = tgt_r; mrl_wd = tpc_pkg::SLOT_NIL;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        if (!mru_r[SW]) begin
          mrl_we = 1'b1; mrl_wa = mru_r[SW-1:0]; mrl_wd = {1'b0, tgt_r};
        end else begin
          lru_nxt = {1'b0, tgt_r};
        end
        mru_nxt            = {1'b0, tgt_r};
        in_use_nxt[tgt_r]  = 1'b1;
        state_nxt          = ST_N_SET;
      end
      ST_N_RT: begin
        tgt_nxt   = s_r;
        ret_nxt   = ST_N_EX;
        state_nxt = ST_T0;
      end
      ST_N_EX: begin
        if ((xk_r < 3'(tpc_pkg::EXTRA_FLUSH)) && !lru_r[SW]) begin
          tgt_nxt     = lru_r[SW-1:0];
          xk_nxt      = xk_r + 3'd1;
          flushed_nxt = flushed_r + 3'd1;
          ret_nxt     = ST_N_EXT;
          state_nxt   = ST_F0;
        end else begin
          state_nxt = ST_N_SET;
        end
      end
      ST_N_EXT: begin
        ret_nxt   = ST_N_EX;
        state_nxt = ST_T0;
      end
      ST_N_SET: begin
        pmap_we   = 1'b1; pmap_wa = page_idx; pmap_wd = {1'b0, s_r};
        spn_we    = 1'b1; spn_wa = s_r; spn_wd = {1'b0, page};
        tgt_nxt   = s_r;
        ret_nxt   = ST_N_LOOK;
        state_nxt = ST_T0;
      end
      ST_N_LOOK: begin
        fhd_ra    = s_r;
        etab_ra   = {s_r, word};
        state_nxt = ST_N_RES;
      end
      ST_N_RES: begin
        res_nxt.page_slot     = 8'(s_r);
        res_nxt.flushed_count = flushed_r;
        if (frag_nil(fhd_rd)) begin
          res_nxt.status = tpc_pkg::STATUS_EMPTY;
        end else begin
          res_nxt.entry_offset = etab_rd;
          res_nxt.status = (etab_rd != '0) ? tpc_pkg::STATUS_HIT : tpc_pkg::STATUS_MISS;
        end
        state_nxt = ST_DONE;
      end

      // fragment allocation
      ST_A_FREE: begin
        ret_nxt   = ST_A_CHK;
        state_nxt = ST_U0;
      end
      ST_A_CHK: begin
        res_nxt.page_slot     = req_r.slot;
        res_nxt.flushed_count = flushed_r;
        if (in_use_r[slot_sel] && !frag_nil(ffh_r)) begin
          fnx_ra    = ffh_r[FW-1:0];
          fhd_ra    = slot_sel;
          state_nxt = ST_A_POP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_A_POP: begin
        ffh_nxt = fnx_rd;
        fnx_we  = 1'b1; fnx_wa = ffh_r[FW-1:0]; fnx_wd = fhd_rd;
        fhd_we  = 1'b1; fhd_wa = slot_sel; fhd_wd = ffh_r;
        res_nxt.status         = tpc_pkg::STATUS_DONE;
        res_nxt.fragment_index = 10'(ffh_r[FW-1:0]);
        state_nxt = ST_DONE;
      end

      // record an entrypoint
      ST_R_MAP: begin
        res_nxt.status = tpc_pkg::STATUS_EMPTY;
        if (pmap_rd[SW]) begin
          state_nxt = ST_DONE;
        end else begin
          s_nxt     = pmap_rd[SW-1:0];
          fhd_ra    = pmap_rd[SW-1:0];
          state_nxt = ST_R_CHK;
        end
      end
      ST_R_CHK: begin
        res_nxt.page_slot = 8'(s_r);
        if (!frag_nil(fhd_rd)) begin
          etab_we = 1'b1; etab_wa = {s_r, word}; etab_wd = req_r.cache_offset;
          res_nxt.status = tpc_pkg::STATUS_DONE;
        end
        state_nxt = ST_DONE;
      end

      // invalidate
      ST_I_FREE: begin
        ret_nxt   = ST_I_END;
        state_nxt = ST_U0;
      end
      ST_I_END: begin
        res_nxt.status        = tpc_pkg::STATUS_DONE;
        res_nxt.page_slot     = req_r.slot;
        res_nxt.flushed_count = flushed_r;
        state_nxt             = ST_DONE;
      end

      // move tgt to the mru end
      ST_T0: begin
        lrl_ra    = tgt_r;
        mrl_ra    = tgt_r;
        state_nxt = ST_T1;
      end
      ST_T1: begin
        if (mrl_rd[SW]) begin
          state_nxt = ret_r;
        end else begin
          if (!lrl_rd[SW]) begin
            mrl_we = 1'b1; mrl_wa = lrl_rd[SW-1:0]; mrl_wd = mrl_rd;
          end else begin
            lru_nxt = mrl_rd;
          end
          lrl_we    = 1'b1; lrl_wa = mrl_rd[SW-1:0]; lrl_wd = lrl_rd;
          state_nxt = ST_T2;
        end
      end
      ST_T2: begin
        lrl_we = 1'b1; lrl_wa = tgt_r; lrl_wd = mru_r;
        if (!mru_r[SW]) begin
          mrl_we = 1'b1; mrl_wa = mru_r[SW-1:0]; mrl_wd = {1'b0, tgt_r};
        end
        state_nxt = ST_T3;
      end
      ST_T3: begin
        mrl_we    = 1'b1; mrl_wa = tgt_r; mrl_wd = tpc_pkg::SLOT_NIL;
        mru_nxt   = {1'b0, tgt_r};
        state_nxt = ret_r;
      end

      // flush tgt: fragments back, mapping dropped, entries cleared
      ST_F0: begin
        fhd_ra    = tgt_r;
        spn_ra    = tgt_r;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        f_nxt     = fhd_rd;
        pg_nxt    = spn_rd;
        fhd_we    = 1'b1; fhd_wa = tgt_r; fhd_wd = tpc_pkg::FRAG_NIL;
        spn_we    = 1'b1; spn_wa = tgt_r; spn_wd = tpc_pkg::SPN_UNMAPPED;
        pmap_ra   = spn_rd[PW-1:0];
        guard_nxt = '0;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        if (!pg_r[SPW-1] && ({1'b0, pg_r} < (SPW + 1)'(tpc_pkg::MAP_PAGES)) &&
            (pmap_rd == {1'b0, tgt_r})) begin
          pmap_we = 1'b1; pmap_wa = pg_r[PW-1:0]; pmap_wd = tpc_pkg::SLOT_NIL;
        end
        state_nxt = ST_FW0;
      end
      ST_FW0: begin
        if (frag_nil(f_r) || (guard_r == (FW + 1)'(tpc_pkg::NUM_FRAGMENTS))) begin
          k_nxt     = '0;
          state_nxt = ST_FC;
        end else begin
          fnx_ra    = f_r[FW-1:0];
          state_nxt = ST_FW1;
        end
      end
      ST_FW1: begin
        fnx_we    = 1'b1; fnx_wa = f_r[FW-1:0]; fnx_wd = ffh_r;
        ffh_nxt   = f_r;
        f_nxt     = fnx_rd;
        guard_nxt = guard_r + 1'b1;
        state_nxt = ST_FW0;
      end
      ST_FC: begin
        etab_we = 1'b1; etab_wa = {tgt_r, k_r}; etab_wd = '0;
        k_nxt   = k_r + 1'b1;
        if (k_r == '1) begin
          state_nxt = ret_r;
        end
      end

      // unlink tgt from the recency list onto the free list
      ST_U0: begin
        lrl_ra    = tgt_r;
        mrl_ra    = tgt_r;
        state_nxt = ST_U1;
      end
      ST_U1: begin
        if (!lrl_rd[SW]) begin
          mrl_we = 1'b1; mrl_wa = lrl_rd[SW-1:0]; mrl_wd = mrl_rd;
        end else begin
          lru_nxt = mrl_rd;
        end
        if (!mrl_rd[SW]) begin
          lrl_we = 1'b1; lrl_wa = mrl_rd[SW-1:0]; lrl_wd = lrl_rd;
        end else begin
          mru_nxt = lrl_rd;
        end
        state_nxt = ST_U2;
      end
      ST_U2: begin
        lrl_we            = 1'b1; lrl_wa = tgt_r; lrl_wd = tpc_pkg::SLOT_NIL;
        mrl_we            = 1'b1; mrl_wa = tgt_r; mrl_wd = free_r;
        free_nxt          = {1'b0, tgt_r};
        in_use_nxt[tgt_r] = 1'b0;
        state_nxt         = ret_r;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state, list pointers, sweep counter and slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      ret_r    <= ST_IDLE;
      lru_r    <= tpc_pkg::SLOT_NIL;
      mru_r    <= tpc_pkg::SLOT_NIL;
      free_r   <= '0;
      ffh_r    <= '0;
      clr_r    <= '0;
      in_use_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      lru_r    <= lru_nxt;
      mru_r    <= mru_nxt;
      free_r   <= free_nxt;
      ffh_r    <= ffh_nxt;
      clr_r    <= clr_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    s_r       <= s_nxt;
    tgt_r     <= tgt_nxt;
    f_r       <= f_nxt;
    pg_r      <= pg_nxt;
    guard_r   <= guard_nxt;
    k_r       <= k_nxt;
    xk_r      <= xk_nxt;
    flushed_r <= flushed_nxt;
  end

  assign idle = (state_r == ST_IDLE);
  assign done = (state_r == ST_DONE);
  assign res  = res_r;

  `TPC_ASSERT_IMP(a_hit_has_offset, done && (res_r.status == tpc_pkg::STATUS_HIT),
                  res_r.entry_offset != '0, "hit reported with zero offset")
  `TPC_ASSERT_IMP(a_frag_only_alloc, done && (res_r.fragment_index != '0),
                  req_r.op == tpc_pkg::OP_ALLOC_FRAG, "fragment given outside alloc")
  `TPC_ASSERT_IMP(a_flush_bound, done,
                  res_r.flushed_count <= 3'(tpc_pkg::EXTRA_FLUSH + 1), "flush count too high")
  `TPC_ASSERT_NXT(a_result_held, done && !res_ready,
                  done && $stable(res_r), "result dropped before handoff")

endmodule
`default_nettype wire

// ===== rtl/translation_page_cache_manager.sv =====
// Translation page cache manager: stream ports, config register, result register.
// Words are taken one at a time; the next word is taken once the sequencer is idle.
// Reset: synchronous, active low; a clearing sweep over the entry table, page map,
//   slot lists and fragment chains follows, during which in_tready stays low
//   (config writes still taken).
`default_nettype none
module translation_page_cache_manager (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // op, address, slot, cache_offset, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // status, page_slot, entry_offset,
                                       // fragment_index, flushed_count, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [31:0]   memsize_r, memsize_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [55:0]   out_data_r, out_data_nxt;
  tpc_pkg::req_t req;
  tpc_pkg::res_t res;
  logic          eng_idle, eng_done, res_ready;

  // unpack the input word
  assign req.op           = in_tdata[1:0];
  assign req.address      = in_tdata[33:2];
  assign req.slot         = in_tdata[41:34];
  assign req.cache_offset = in_tdata[72:42];

  assign in_tready = eng_idle;
  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_tready;

  tpc_engine u_engine (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid && in_tready), .req(req),
    .memory_size(memsize_r), .idle(eng_idle), .done(eng_done), .res(res),
    .res_ready(res_ready));

  // output register and config register
  always_comb begin
    memsize_nxt   = memsize_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cfg_valid) begin
      memsize_nxt = cfg_data;
    end
    if (eng_done && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, res.flushed_count, res.fragment_index, res.entry_offset,
                       res.page_slot, res.status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memsize_r   <= tpc_pkg::MEMSIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      memsize_r   <= memsize_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
